// ===== src/pal_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the page allocator.
package pal_pkg;

    localparam int MAX_PAGES = 256;
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int OP_W      = 2;
    localparam int SIZE_W    = 32;
    localparam int ADDR_W    = 40;

    localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = 32'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOCK   = 2'd2,
        OP_UNLOCK = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the item and read the top of the free stack
        logic select;   // pick the page index and register its address
        logic commit;   // update the page state and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_room; // the result register can take a new result this cycle
    } dp_status_t;

endpackage

// ===== src/pal_ctrl.sv =====
// Controller state machine that sequences one request through accept, select and commit.
module pal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pal_pkg::dp_status_t status,
    output pal_pkg::ctrl_cmd_t  cmd
);
    import pal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SELECT = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // Hold here until the previous result has left the output register.
                if (status.out_room)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/pal_datapath.sv =====
// Datapath: page state bits, free stack memory, address multiplier and result register.
module pal_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pal_pkg::ctrl_cmd_t           cmd,
    output pal_pkg::dp_status_t          status,
    input  logic                         cfg_write_en,
    input  logic [pal_pkg::SIZE_W-1:0]   cfg_write_data,
    input  logic [pal_pkg::OP_W-1:0]     opcode,
    input  logic [pal_pkg::IDX_W-1:0]    page_index,
    input  logic [pal_pkg::ADDR_W-1:0]   unlock_address,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic [pal_pkg::IDX_W-1:0]    result_index,
    output logic [pal_pkg::ADDR_W-1:0]   page_address,
    output logic [pal_pkg::CNT_W-1:0]    used_pages
);
    import pal_pkg::*;

    localparam logic [CNT_W-1:0] PAGES_LIMIT = CNT_W'(MAX_PAGES);

    logic [SIZE_W-1:0]    page_size_reg;
    op_t                  op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]    uaddr_reg;
    logic [IDX_W-1:0]     stack_rd_reg;
    logic [IDX_W-1:0]     sel_idx_reg;
    logic                 alloc_ok_reg;
    logic [ADDR_W-1:0]    prod_reg;

    logic [CNT_W-1:0]     high_water_reg;
    logic [CNT_W-1:0]     free_top_reg;
    logic [CNT_W-1:0]     used_count_reg;
    logic [MAX_PAGES-1:0] mapped_reg;
    logic [MAX_PAGES-1:0] locked_reg;
    logic [IDX_W-1:0]     stack_mem [MAX_PAGES];

    logic                 out_valid_reg;
    logic                 ok_reg;
    logic [IDX_W-1:0]     result_index_reg;
    logic [ADDR_W-1:0]    page_address_reg;
    logic [CNT_W-1:0]     used_pages_reg;

    logic [CNT_W-1:0]     high_water_next;
    logic [CNT_W-1:0]     free_top_next;
    logic [CNT_W-1:0]     used_count_next;
    logic                 ok_next;
    logic [IDX_W-1:0]     result_index_next;
    logic [ADDR_W-1:0]    page_address_next;

    logic                 from_stack;
    logic                 alloc_ok;
    logic [IDX_W-1:0]     alloc_idx;
    logic [IDX_W-1:0]     sel_idx;
    logic [IDX_W-1:0]     top_addr;
    logic                 known;
    logic                 mapped_bit;
    logic                 locked_bit;

    assign top_addr   = IDX_W'(free_top_reg - CNT_W'(1));
    assign from_stack = (free_top_reg != '0);
    assign alloc_ok   = from_stack || (high_water_reg < PAGES_LIMIT);
    assign alloc_idx  = from_stack ? stack_rd_reg : IDX_W'(high_water_reg);
    assign sel_idx    = (op_reg == OP_ALLOC) ? alloc_idx : idx_reg;

    assign known      = ({1'b0, idx_reg} < high_water_reg);
    assign mapped_bit = mapped_reg[idx_reg];
    assign locked_bit = locked_reg[idx_reg];

    assign status.out_room = !out_valid_reg || !out_stall;

    always_comb
    begin
        ok_next           = 1'b0;
        result_index_next = idx_reg;
        page_address_next = '0;
        high_water_next   = high_water_reg;
        free_top_next     = free_top_reg;
        used_count_next   = used_count_reg;
        case (op_reg)
            OP_ALLOC:
            begin
                ok_next           = alloc_ok_reg;
                result_index_next = alloc_ok_reg ? sel_idx_reg : '0;
                if (alloc_ok_reg)
                begin
                    page_address_next = prod_reg;
                    used_count_next   = used_count_reg + CNT_W'(1);
                    if (from_stack)
                    begin
                        free_top_next = free_top_reg - CNT_W'(1);
                    end
                    else
                    begin
                        high_water_next = high_water_reg + CNT_W'(1);
                    end
                end
            end
            OP_FREE:
            begin
                ok_next = known && mapped_bit && !locked_bit && (free_top_reg < PAGES_LIMIT);
                if (ok_next)
                begin
                    free_top_next = free_top_reg + CNT_W'(1);
                    if (used_count_reg != '0)
                    begin
                        used_count_next = used_count_reg - CNT_W'(1);
                    end
                end
            end
            OP_LOCK:
            begin
                ok_next = known && mapped_bit && !locked_bit;
                if (ok_next)
                begin
                    page_address_next = prod_reg;
                end
            end
            default:
            begin
                ok_next = known && mapped_bit && locked_bit && (prod_reg == uaddr_reg);
            end
        endcase
    end

    // Item and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= op_t'(opcode);
            idx_reg      <= page_index;
            uaddr_reg    <= unlock_address;
        end
        if (cmd.select)
        begin
            sel_idx_reg  <= sel_idx;
            alloc_ok_reg <= alloc_ok;
            prod_reg     <= ADDR_W'(sel_idx) * ADDR_W'(page_size_reg);
        end
        if (cmd.commit)
        begin
            ok_reg           <= ok_next;
            result_index_reg <= result_index_next;
            page_address_reg <= page_address_next;
            used_pages_reg   <= used_count_next;
        end
    end

    // Free stack memory: registered read of the top entry, write on a successful free.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stack_rd_reg <= stack_mem[top_addr];
        end
        if (cmd.commit && (op_reg == OP_FREE) && ok_next)
        begin
            stack_mem[IDX_W'(free_top_reg)] <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg  <= PAGE_SIZE_RESET;
            high_water_reg <= '0;
            free_top_reg   <= '0;
            used_count_reg <= '0;
            mapped_reg     <= '0;
            locked_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                page_size_reg <= cfg_write_data;
            end
            if (cmd.commit)
            begin
                high_water_reg <= high_water_next;
                free_top_reg   <= free_top_next;
                used_count_reg <= used_count_next;
                if (ok_next)
                begin
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            mapped_reg[sel_idx_reg] <= 1'b1;
                            locked_reg[sel_idx_reg] <= 1'b0;
                        end
                        OP_FREE:
                        begin
                            mapped_reg[idx_reg] <= 1'b0;
                        end
                        OP_LOCK:
                        begin
                            locked_reg[idx_reg] <= 1'b1;
                        end
                        default:
                        begin
                            locked_reg[idx_reg] <= 1'b0;
                        end
                    endcase
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign result_index = result_index_reg;
    assign page_address = page_address_reg;
    assign used_pages   = used_pages_reg;

endmodule

// ===== src/page_allocator_with_lock_bits_top.sv =====
// Top level of the page allocator with per-page lock bits.
//
//   Channel   Direction  Handshake              Contents
//   request   in         in_valid / in_stall    opcode, page_index, unlock_address
//   result    out        out_valid / out_stall  ok, result_index, page_address, used_pages
//   config    in         cfg_write_en           cfg_write_data -> page size register
//
// Each request passes the accept, select and commit steps: accept reads the top of the
// free stack memory, select multiplies the index by the page size, and commit writes the
// state change into the result register; a new item is taken only after the last commits.
// The result register lets the next item enter while a result waits; a stalled
// result holds the commit step until it leaves. Reset clears the page state bits,
// the counters and the result valid flag at once; there is no clearing pass.
module page_allocator_with_lock_bits_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [pal_pkg::SIZE_W-1:0]   cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [pal_pkg::OP_W-1:0]     opcode,
    input  logic [pal_pkg::IDX_W-1:0]    page_index,
    input  logic [pal_pkg::ADDR_W-1:0]   unlock_address,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic [pal_pkg::IDX_W-1:0]    result_index,
    output logic [pal_pkg::ADDR_W-1:0]   page_address,
    output logic [pal_pkg::CNT_W-1:0]    used_pages
);
    import pal_pkg::*;

    // The controller only sequences; all storage and arithmetic sit in the datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    pal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pal_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (opcode),
        .page_index     (page_index),
        .unlock_address (unlock_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .result_index   (result_index),
        .page_address   (page_address),
        .used_pages     (used_pages)
    );

endmodule

// ===== src/pal_checker.sv =====
// Port-level checker for the page allocator, bound to the top level.
module pal_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         ok,
    input logic [pal_pkg::ADDR_W-1:0]   page_address,
    input logic [pal_pkg::CNT_W-1:0]    used_pages
);
    import pal_pkg::*;

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted on two consecutive cycles");

    // A refused request or a failed allocation never reports an address.
    a_refused_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (page_address == '0))
        else $error("refused result carries a page address");

    // The mapped page count never exceeds the number of pages.
    a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (used_pages <= CNT_W'(MAX_PAGES)))
        else $error("used page count out of range");

    // A stalled result holds its contents.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ok) && $stable(page_address)
            && $stable(used_pages)))
        else $error("stalled result changed");

endmodule

bind page_allocator_with_lock_bits_top pal_checker u_pal_checker (.*);

// ===== bench/page_allocator_with_lock_bits_top_tb.sv =====
// Self-checking testbench for the page allocator with per-page lock bits.
import pal_pkg::*;

// Tracks the page table the block should hold and the results it should give.
class page_scoreboard;

    typedef struct {
        logic              ok;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  used;
    } page_result_t;

    logic [SIZE_W-1:0] page_size;
    int unsigned       high_water;
    int unsigned       stack_depth;
    int unsigned       used_count;
    bit                mapped [MAX_PAGES];
    bit                locked [MAX_PAGES];
    logic [IDX_W-1:0]  free_stack [MAX_PAGES];
    page_result_t      pending_results [$];

    int errors;
    int requests;
    int results;
    int granted;
    int alloc_failures;
    int peak_used;

    function new();
        page_size   = PAGE_SIZE_RESET;
        high_water  = 0;
        stack_depth = 0;
        used_count  = 0;
        foreach (mapped[i])
        begin
            mapped[i] = 1'b0;
            locked[i] = 1'b0;
        end
        errors = 0;
        requests = 0;
        results = 0;
        granted = 0;
        alloc_failures = 0;
        peak_used = 0;
    endfunction

    // Exact product, wide enough that no index and page size can overflow it.
    function logic [63:0] address_of(logic [IDX_W-1:0] idx);
        logic [63:0] a;
        logic [63:0] b;
        a = {{(64-IDX_W){1'b0}}, idx};
        b = {{(64-SIZE_W){1'b0}}, page_size};
        return a * b;
    endfunction

    function void note_request(op_t op, logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] ua);
        page_result_t r;
        logic [63:0]  product;
        bit           known;
        int           slot;
        slot = int'(idx);
        known = slot < int'(high_water);
        product = address_of(idx);
        r.ok = 1'b0;
        r.index = idx;
        r.address = '0;
        requests++;
        case (op)
            OP_ALLOC:
            begin
                r.index = '0;
                if (stack_depth > 0)
                begin
                    stack_depth--;
                    r.index = free_stack[stack_depth];
                    r.ok = 1'b1;
                end
                else if (high_water < MAX_PAGES)
                begin
                    r.index = IDX_W'(high_water);
                    high_water++;
                    r.ok = 1'b1;
                end
                else
                    alloc_failures++;
                if (r.ok)
                begin
                    mapped[r.index] = 1'b1;
                    locked[r.index] = 1'b0;
                    used_count++;
                    product = address_of(r.index);
                    r.address = product[ADDR_W-1:0];
                end
            end
            OP_FREE:
            begin
                if (known && mapped[slot] && !locked[slot] && stack_depth < MAX_PAGES)
                begin
                    mapped[slot] = 1'b0;
                    free_stack[stack_depth] = idx;
                    stack_depth++;
                    if (used_count > 0)
                        used_count--;
                    r.ok = 1'b1;
                end
            end
            OP_LOCK:
            begin
                if (known && mapped[slot] && !locked[slot])
                begin
                    locked[slot] = 1'b1;
                    r.address = product[ADDR_W-1:0];
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                // The full product is compared, so an address past 40 bits never matches.
                if (known && mapped[slot] && locked[slot] &&
                    product == {{(64-ADDR_W){1'b0}}, ua})
                begin
                    locked[slot] = 1'b0;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.used = CNT_W'(used_count);
        if (r.ok)
            granted++;
        if (int'(used_count) > peak_used)
            peak_used = int'(used_count);
        pending_results.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(logic ok, logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] addr,
                      logic [CNT_W-1:0] used);
        page_result_t e;
        results++;
        if (pending_results.size() == 0)
        begin
            report("result arrived with nothing expected");
            return;
        end
        e = pending_results.pop_front();
        if (ok !== e.ok)
            report($sformatf("ok got %b expected %b", ok, e.ok));
        if (idx !== e.index)
            report($sformatf("result_index got %0d expected %0d", idx, e.index));
        if (addr !== e.address)
            report($sformatf("page_address got %h expected %h", addr, e.address));
        if (used !== e.used)
            report($sformatf("used_pages got %0d expected %0d", used, e.used));
    endtask

endclass

module page_allocator_with_lock_bits_top_tb;

    // Length of the one long result hold-off that backs the block up.
    localparam int HOLD_CYCLES = 120;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_en;
    logic [SIZE_W-1:0] cfg_write_data;
    logic              in_valid;
    logic              in_stall;
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  page_index;
    logic [ADDR_W-1:0] unlock_address;
    logic              out_valid;
    logic              out_stall;
    logic              ok;
    logic [IDX_W-1:0]  result_index;
    logic [ADDR_W-1:0] page_address;
    logic [CNT_W-1:0]  used_pages;

    page_scoreboard sb;

    // Idle control shared between the request driver and the result receiver.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_wanted = 1'b0;

    page_allocator_with_lock_bits_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .page_index     (page_index),
        .unlock_address (unlock_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .result_index   (result_index),
        .page_address   (page_address),
        .used_pages     (used_pages)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both handshakes are sampled at the clock edge, before any update made at
    // that edge takes effect. A result is checked before the request taken at
    // the same edge is predicted, since no request can finish at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(ok, result_index, page_address, used_pages);
            if (in_valid && !in_stall)
                sb.note_request(op_t'(opcode), page_index, unlock_address);
        end
    end

    // The result receiver stalls about a third of the time, never while the
    // steady flag is up, and once holds off for a long stretch so that the
    // result register and the pipeline fill and the block stalls its input.
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_steady)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 35);
        end
    end

    // Offers one item, with a random gap first unless the sender is steady,
    // and returns at the edge where the block takes it. Valid stays high on
    // return so that back-to-back items need no gap between them.
    task automatic request(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [ADDR_W-1:0] ua);
        while (!tx_steady && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        page_index     <= idx;
        unlock_address <= ua;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops offering items and waits until every predicted result has come.
    // The first edge lets the monitor record the item taken at this edge.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The page size is only rewritten once the block has gone quiet.
    task automatic set_page_size(input logic [SIZE_W-1:0] value);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.page_size = value;
    endtask

    // Random requests, mostly aimed at pages that have been handed out and,
    // for unlock, mostly carrying the right address so that locked pages get
    // released again. The allocate weight steers the table toward full or
    // toward empty.
    task automatic random_phase(input int count, input int alloc_weight);
        int                n;
        int                pick;
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [63:0]       noise;
        logic [63:0]       product;
        logic [ADDR_W-1:0] ua;
        for (n = 0; n < count; n++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < alloc_weight)
                op = OP_ALLOC;
            else if (pick % 3 == 0)
                op = OP_FREE;
            else if (pick % 3 == 1)
                op = OP_LOCK;
            else
                op = OP_UNLOCK;
            if (sb.high_water > 0 && $urandom_range(0, 99) < 80)
                idx = IDX_W'($urandom_range(0, sb.high_water - 1));
            else
                idx = IDX_W'($urandom_range(0, MAX_PAGES - 1));
            noise = {$urandom, $urandom};
            product = sb.address_of(idx);
            ua = product[ADDR_W-1:0];
            pick = int'($urandom_range(0, 9));
            if (pick == 0)
                ua = noise[ADDR_W-1:0];
            else if (pick == 1)
                ua = ua ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
            request(op, idx, ua);
        end
    endtask

    initial
    begin
        int k;
        int wait_count;
        sb = new();
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        opcode         <= OP_ALLOC;
        page_index     <= '0;
        unlock_address <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset page size of 4096 bytes. Requests on
        // indices never handed out come first, then the life of a few pages:
        // lock, double lock, free of a locked page, unlock with a wrong and a
        // right address, double free, and reuse of freed pages in LIFO order.
        request(OP_FREE,   8'd0,   40'd0);
        request(OP_LOCK,   8'd255, 40'd0);
        request(OP_UNLOCK, 8'd0,   40'd0);
        request(OP_ALLOC,  8'd0,   40'd0);
        request(OP_ALLOC,  8'd0,   40'd0);
        request(OP_ALLOC,  8'd0,   40'd0);
        request(OP_LOCK,   8'd1,   40'd0);
        request(OP_LOCK,   8'd1,   40'd0);
        request(OP_FREE,   8'd1,   40'd0);
        request(OP_UNLOCK, 8'd1,   40'd4097);
        request(OP_UNLOCK, 8'd1,   40'd4096);
        request(OP_UNLOCK, 8'd1,   40'd4096);
        request(OP_FREE,   8'd2,   40'd0);
        request(OP_FREE,   8'd2,   40'd0);
        request(OP_LOCK,   8'd2,   40'd0);
        request(OP_UNLOCK, 8'd2,   40'd8192);
        request(OP_ALLOC,  8'd0,   40'd0);
        request(OP_FREE,   8'd0,   40'd0);
        request(OP_FREE,   8'd2,   40'd0);
        request(OP_ALLOC,  8'd0,   40'd0);
        request(OP_ALLOC,  8'd0,   40'd0);
        request(OP_UNLOCK, 8'd255, 40'hFF_FFFF_FFFF);
        request(OP_LOCK,   8'd0,   40'd0);
        request(OP_UNLOCK, 8'd0,   40'd0);

        // Smallest nonzero page size. The middle of this phase runs with no idling on
        // either side so that items go through at the block's full rate.
        set_page_size(32'd1);
        random_phase(100, 50);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_phase(150, 50);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Largest page size with an allocate-heavy mix: the table fills and
        // allocations start to fail. Early on the receiver holds off for a
        // long stretch while items keep coming.
        set_page_size(32'hFFFF_FFFF);
        random_phase(40, 85);
        hold_wanted = 1'b1;
        random_phase(360, 85);

        // A page size of zero is accepted and makes every address zero.
        // A free-heavy mix drains the table again.
        set_page_size(32'd0);
        random_phase(300, 20);

        // A few random page sizes. In each the sender stops once until all
        // results are back before going on.
        for (k = 0; k < 3; k++)
        begin
            if (k == 1)
                set_page_size(SIZE_W'($urandom_range(2, 5000)));
            else
                set_page_size(SIZE_W'($urandom));
            random_phase(120, 50);
            drain_results();
            random_phase(130, 50);
        end

        // Every item causes exactly one result, so once nothing is pending
        // the block is quiet after a short wait.
        in_valid <= 1'b0;
        wait_count = 0;
        @(posedge clk);
        while (sb.pending_results.size() != 0 && wait_count < 5000)
        begin
            @(posedge clk);
            wait_count++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

        $display("Ran %0d requests and checked %0d results over seven page sizes, zero and",
                 sb.requests, sb.results);
        $display("the maximum among them: %0d granted, %0d failed allocations, peak %0d pages.",
                 sb.granted, sb.alloc_failures, sb.peak_used);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
